// File: rtl/y2r_pkg.sv
`default_nettype none

package y2r_pkg;

  localparam int UB_NUM = 1772;
  localparam int UB_DEN = 1000;
  localparam int UG_NUM = 34414;
  localparam int UG_DEN = 100000;
  localparam int VG_NUM = 71414;
  localparam int VG_DEN = 100000;
  localparam int VR_NUM = 1402;
  localparam int VR_DEN = 1000;
  localparam int CHROMA_OFFSET = 128;

  typedef logic signed [8:0] term_t;
  typedef logic signed [9:0] chan_t;
  typedef term_t term_tab_t [256];

  typedef struct packed {
    term_t ub;
    term_t ugvg;
    term_t vr;
  } chroma_t;

  // C-style division: truncates toward zero
  function automatic term_tab_t build_ub();
    term_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 9'(((i - CHROMA_OFFSET) * UB_NUM) / UB_DEN);
    end
    return t;
  endfunction

  function automatic term_tab_t build_ug();
    term_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 9'(((i - CHROMA_OFFSET) * UG_NUM) / UG_DEN);
    end
    return t;
  endfunction

  function automatic term_tab_t build_vg();
    term_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 9'(((i - CHROMA_OFFSET) * VG_NUM) / VG_DEN);
    end
    return t;
  endfunction

  function automatic term_tab_t build_vr();
    term_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 9'(((i - CHROMA_OFFSET) * VR_NUM) / VR_DEN);
    end
    return t;
  endfunction

  localparam term_tab_t UB_TAB = build_ub();
  localparam term_tab_t UG_TAB = build_ug();
  localparam term_tab_t VG_TAB = build_vg();
  localparam term_tab_t VR_TAB = build_vr();

  function automatic logic [7:0] clamp8(chan_t x);
    logic [7:0] r;
    if (x < 0) begin
      r = 8'd0;
    end else if (x > 10'sd255) begin
      r = 8'hFF;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/yuv420_block_to_rgb565_core.sv
`default_nettype none

// Channel | handshake           | payload
// --------+---------------------+-------------------------------------------
// in      | in_valid, in_ready  | luma_top_left/right, luma_bottom_left/right,
//         |                     | chroma_blue, chroma_red (8 bits each)
// out     | out_valid, out_ready| top_row_word, bottom_row_word (32 bits each)
//
// Three register stages: input capture, chroma table lookup, pixel pack.
// out_valid is the third stage's valid bit; one block per cycle while out_ready is high.
// Each stage holds when the next one is full and stalled; a bubble lets
// the stages behind it move up, so in_ready falls only with all three full.
// rst (synchronous) clears the stage valid bits; data registers are not reset.

module yuv420_block_to_rgb565_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  luma_top_left,
  input  wire logic [7:0]  luma_top_right,
  input  wire logic [7:0]  luma_bottom_left,
  input  wire logic [7:0]  luma_bottom_right,
  input  wire logic [7:0]  chroma_blue,
  input  wire logic [7:0]  chroma_red,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      top_row_word,
  output logic [31:0]      bottom_row_word
);

  logic       v1;
  logic       v2;
  logic       v3;
  logic       en1;
  logic       en2;
  logic       en3;

  logic [7:0] luma1 [4];
  logic [7:0] cb1;
  logic [7:0] cr1;

  logic [7:0]        luma2 [4];
  y2r_pkg::chroma_t  chroma2;
  y2r_pkg::chroma_t  chroma_next;

  logic [15:0] rgb [4];
  logic [31:0] top3;
  logic [31:0] bot3;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      luma1[0] <= luma_top_left;
      luma1[1] <= luma_top_right;
      luma1[2] <= luma_bottom_left;
      luma1[3] <= luma_bottom_right;
      cb1      <= chroma_blue;
      cr1      <= chroma_red;
    end
  end

  always_comb begin
    chroma_next.ub   = y2r_pkg::UB_TAB[cb1];
    chroma_next.ugvg = y2r_pkg::UG_TAB[cb1] + y2r_pkg::VG_TAB[cr1];
    chroma_next.vr   = y2r_pkg::VR_TAB[cr1];
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      luma2   <= luma1;
      chroma2 <= chroma_next;
    end
  end

  for (genvar p = 0; p < 4; p++) begin : g_pix
    y2r_pixel u_pix (
      .luma   (luma2[p]),
      .chroma (chroma2),
      .rgb    (rgb[p])
    );
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      top3 <= {rgb[1], rgb[0]};
      bot3 <= {rgb[3], rgb[2]};
    end
  end

  assign out_valid       = v3;
  assign top_row_word    = top3;
  assign bottom_row_word = bot3;

  a_in_to_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("input transfer did not fill stage 1");

  a_s2_to_s3: assert property (@(posedge clk) disable iff (rst)
    (v2 && en3) |=> v3)
    else $error("stage 2 item lost on advance");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && !out_ready))
    else $error("input held off with a free stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !v3))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// File: rtl/y2r_pixel.sv
`default_nettype none

module y2r_pixel (
  input  wire logic [7:0]       luma,
  input  wire y2r_pkg::chroma_t chroma,
  output logic [15:0]           rgb
);

  y2r_pkg::chan_t y_s;
  y2r_pkg::chan_t b_s;
  y2r_pkg::chan_t g_s;
  y2r_pkg::chan_t r_s;
  logic [7:0]     b_c;
  logic [7:0]     g_c;
  logic [7:0]     r_c;

  always_comb begin
    y_s = $signed({2'b00, luma});
    b_s = y_s + 10'(chroma.ub);
    g_s = y_s - 10'(chroma.ugvg);
    r_s = y_s + 10'(chroma.vr);
    b_c = y2r_pkg::clamp8(b_s);
    g_c = y2r_pkg::clamp8(g_s);
    r_c = y2r_pkg::clamp8(r_s);
    rgb = {r_c[7:3], g_c[7:2], b_c[7:3]};
  end

endmodule

`default_nettype wire

// File: tb/sv/block_colour_checker.sv
`timescale 1ns / 100ps

module block_colour_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  luma_top_left,
  input  logic [7:0]  luma_top_right,
  input  logic [7:0]  luma_bottom_left,
  input  logic [7:0]  luma_bottom_right,
  input  logic [7:0]  chroma_blue,
  input  logic [7:0]  chroma_red,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] top_row_word,
  input  logic [31:0] bottom_row_word,
  output int          failures,
  output int          pending
);

  localparam int BLUE_NUM      = 1772;
  localparam int BLUE_DEN      = 1000;
  localparam int GREEN_U_NUM   = 34414;
  localparam int GREEN_V_NUM   = 71414;
  localparam int GREEN_DEN     = 100000;
  localparam int RED_NUM       = 1402;
  localparam int RED_DEN       = 1000;
  localparam int CHROMA_CENTRE = 128;

  typedef struct packed {
    logic [31:0] top;
    logic [31:0] bottom;
  } row_pair_t;

  row_pair_t expected_rows[$];
  int        mismatch_count = 0;

  function automatic logic [7:0] saturate(int x);
    logic [7:0] r;
    if (x < 0) begin
      r = 8'h00;
    end else if (x > 255) begin
      r = 8'hFF;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] to_rgb565(int y, int blue_term, int green_term,
                                            int red_term);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = saturate(y + red_term);
    g = saturate(y - green_term);
    b = saturate(y + blue_term);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic row_pair_t convert_block(logic [7:0] tl, logic [7:0] tr,
                                              logic [7:0] bl, logic [7:0] br,
                                              logic [7:0] cb, logic [7:0] cr);
    int u;
    int v;
    int blue_term;
    int green_term;
    int red_term;
    row_pair_t rows;
    u = int'(cb) - CHROMA_CENTRE;
    v = int'(cr) - CHROMA_CENTRE;
    // integer division truncates toward zero
    blue_term  = (BLUE_NUM * u) / BLUE_DEN;
    green_term = (GREEN_U_NUM * u) / GREEN_DEN + (GREEN_V_NUM * v) / GREEN_DEN;
    red_term   = (RED_NUM * v) / RED_DEN;
    rows.top    = {to_rgb565(int'(tr), blue_term, green_term, red_term),
                   to_rgb565(int'(tl), blue_term, green_term, red_term)};
    rows.bottom = {to_rgb565(int'(br), blue_term, green_term, red_term),
                   to_rgb565(int'(bl), blue_term, green_term, red_term)};
    return rows;
  endfunction

  always @(posedge clk) begin : watch
    row_pair_t oldest;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_rows.push_back(convert_block(luma_top_left, luma_top_right,
                                              luma_bottom_left, luma_bottom_right,
                                              chroma_blue, chroma_red));
      end
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          $error("output transfer with no block pending: top %h bottom %h",
                 top_row_word, bottom_row_word);
          mismatch_count++;
        end else begin
          oldest = expected_rows.pop_front();
          if (top_row_word !== oldest.top) begin
            $error("top_row_word: expected %h, got %h", oldest.top, top_row_word);
            mismatch_count++;
          end
          if (bottom_row_word !== oldest.bottom) begin
            $error("bottom_row_word: expected %h, got %h", oldest.bottom,
                   bottom_row_word);
            mismatch_count++;
          end
        end
      end
    end
    failures <= mismatch_count;
    pending  <= expected_rows.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_BLOCKS = 1950;
  localparam int STALL_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 8;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  luma_top_left = 8'h00;
  logic [7:0]  luma_top_right = 8'h00;
  logic [7:0]  luma_bottom_left = 8'h00;
  logic [7:0]  luma_bottom_right = 8'h00;
  logic [7:0]  chroma_blue = 8'h00;
  logic [7:0]  chroma_red = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] top_row_word;
  logic [31:0] bottom_row_word;
  logic        calm = 1'b0;
  int          failures;
  int          pending;
  int          stall_cycles = 0;

  yuv420_block_to_rgb565_core i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .luma_top_left     (luma_top_left),
    .luma_top_right    (luma_top_right),
    .luma_bottom_left  (luma_bottom_left),
    .luma_bottom_right (luma_bottom_right),
    .chroma_blue       (chroma_blue),
    .chroma_red        (chroma_red),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .top_row_word      (top_row_word),
    .bottom_row_word   (bottom_row_word)
  );

  block_colour_checker i_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .luma_top_left     (luma_top_left),
    .luma_top_right    (luma_top_right),
    .luma_bottom_left  (luma_bottom_left),
    .luma_bottom_right (luma_bottom_right),
    .chroma_blue       (chroma_blue),
    .chroma_red        (chroma_red),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .top_row_word      (top_row_word),
    .bottom_row_word   (bottom_row_word),
    .failures          (failures),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[yuv420_block_to_rgb565_core] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_luma();
    logic [7:0] r;
    case ($urandom_range(7))
      0:       r = 8'h00;
      1:       r = 8'hFF;
      default: r = 8'($urandom);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_chroma();
    logic [7:0] r;
    case ($urandom_range(11))
      0:       r = 8'h00;
      1:       r = 8'hFF;
      2:       r = 8'd127;
      3:       r = 8'd128;
      4:       r = 8'd129;
      default: r = 8'($urandom);
    endcase
    return r;
  endfunction

  // holds valid across back-to-back transfers; drops it only for an idle gap
  task automatic send_block(input logic [7:0] tl, input logic [7:0] tr,
                            input logic [7:0] bl, input logic [7:0] br,
                            input logic [7:0] cb, input logic [7:0] cr);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    luma_top_left     <= tl;
    luma_top_right    <= tr;
    luma_bottom_left  <= bl;
    luma_bottom_right <= br;
    chroma_blue       <= cb;
    chroma_red        <= cr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // neutral chroma, luma extremes
    send_block(8'h00, 8'hFF, 8'hFF, 8'h00, 8'd128, 8'd128);
    // red and blue clamped low / high
    send_block(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_block(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // green driven past 255 and below 0
    send_block(8'hFF, 8'hF0, 8'hC0, 8'h80, 8'h00, 8'h00);
    send_block(8'h00, 8'h10, 8'h40, 8'h80, 8'hFF, 8'hFF);
    // one chroma at each extreme
    send_block(8'h80, 8'h00, 8'hFF, 8'h40, 8'h00, 8'hFF);
    send_block(8'h80, 8'h00, 8'hFF, 8'h40, 8'hFF, 8'h00);
    // just either side of the centre, then other mixed values
    send_block(8'h10, 8'h20, 8'h30, 8'h40, 8'd127, 8'd129);
    send_block(8'h10, 8'h20, 8'h30, 8'h40, 8'd129, 8'd127);
    send_block(8'h01, 8'hFE, 8'h7F, 8'h80, 8'd1, 8'd254);
    send_block(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
    send_block(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
    // mid luma with strong chroma, close to the clamp edges
    send_block(8'd29, 8'd30, 8'd226, 8'd227, 8'd255, 8'd128);
    send_block(8'd179, 8'd180, 8'd77, 8'd78, 8'd128, 8'd0);

    for (int n = 0; n < RANDOM_BLOCKS; n++) begin
      calm <= (n >= 700) && (n < 1000);
      send_block(pick_luma(), pick_luma(), pick_luma(), pick_luma(),
                 pick_chroma(), pick_chroma());
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("[yuv420_block_to_rgb565_core] OK");
    end else begin
      $display("[yuv420_block_to_rgb565_core] ERROR");
    end
    $finish;
  end

endmodule
